// ===== sv/assert_macros.svh =====
// assertion macros for the rtl of the graph walker
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on rising clk, disabled while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on rising clk, disabled while rst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/dpl_pkg.sv =====
// package for the word graph walker: record layout, opcodes, fsm states
// no dependencies; used by dpl_table, dpl_walk and dawg_path_lookup
package dpl_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LINK_W   = 24;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned TADDR_W  = 16;
    localparam int unsigned POS_W    = 25;

    localparam int unsigned REC_MORE_BIT = 31;
    localparam int unsigned REC_LET_LO   = 24;
    localparam int unsigned REC_LET_HI   = 30;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } walk_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [LINK_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [LINK_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== sv/dpl_table.sv =====
// graph record memory: one write port, one read port, registered read data
// depends on dpl_pkg
module dpl_table #(
    parameter int unsigned TABLE_DEPTH = 65536
) (
    input  logic                        clk,
    input  dpl_pkg::mem_req_t           req,
    output logic [dpl_pkg::WORD_W-1:0]  rd_data
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [dpl_pkg::WORD_W-1:0] table_mem [TABLE_DEPTH];
    logic [dpl_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            table_mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= table_mem[req.rd_addr[ADDR_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dpl_walk.sv =====
// sibling scan sequencer: takes commands, issues table reads and writes,
// tracks the current node and emits the word result; depends on dpl_pkg
`include "assert_macros.svh"

module dpl_walk #(
    parameter int unsigned TABLE_DEPTH = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [dpl_pkg::TADDR_W-1:0]   table_address,
    input  logic [dpl_pkg::WORD_W-1:0]    table_word,
    input  logic [dpl_pkg::LETTER_W-1:0]  letter,
    input  logic                          last_letter,
    output logic                          done,
    output logic                          word_found,
    output logic [dpl_pkg::LINK_W-1:0]    end_node,
    output dpl_pkg::mem_req_t             mem_req,
    input  logic [dpl_pkg::WORD_W-1:0]    rd_data
);

    localparam logic [dpl_pkg::POS_W-1:0] DEPTH_L = dpl_pkg::POS_W'(TABLE_DEPTH);

    dpl_pkg::walk_state_t state_reg, state_next;

    logic [dpl_pkg::LINK_W-1:0]   cur_node_reg, cur_node_next;
    logic                         failed_reg, failed_next;
    logic [dpl_pkg::LINK_W-1:0]   pos_reg, pos_next;
    logic [dpl_pkg::LETTER_W-1:0] letter_reg, letter_next;
    logic                         last_reg, last_next;
    logic                         done_reg, done_next;
    logic                         found_reg, found_next;
    logic [dpl_pkg::LINK_W-1:0]   node_reg, node_next;

    logic                         accept;
    logic                         wr_in_range;
    logic                         cur_in_range;
    logic [dpl_pkg::POS_W-1:0]    pos_inc;
    logic                         inc_in_range;
    logic                         scan_hit;
    logic                         scan_more;
    logic                         scan_go_on;
    logic                         finish;

    assign accept       = start && (state_reg == dpl_pkg::S_IDLE);
    assign wr_in_range  = {{(dpl_pkg::POS_W-dpl_pkg::TADDR_W){1'b0}}, table_address} < DEPTH_L;
    assign cur_in_range = {1'b0, cur_node_reg} < DEPTH_L;
    assign pos_inc      = {1'b0, pos_reg} + dpl_pkg::POS_W'(1);
    assign inc_in_range = pos_inc < DEPTH_L;
    assign scan_hit     = rd_data[dpl_pkg::REC_LET_HI:dpl_pkg::REC_LET_LO] == letter_reg;
    assign scan_more    = rd_data[dpl_pkg::REC_MORE_BIT];
    assign scan_go_on   = !scan_hit && scan_more && inc_in_range;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpl_pkg::S_IDLE:
            begin
                if (accept && (opcode == dpl_pkg::OP_LOOKUP) && !failed_reg && cur_in_range)
                begin
                    state_next = dpl_pkg::S_SCAN;
                end
            end
            dpl_pkg::S_SCAN:
            begin
                if (!scan_go_on)
                begin
                    state_next = dpl_pkg::S_IDLE;
                end
            end
            default: state_next = dpl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_req         = '0;
        mem_req.wr_addr = dpl_pkg::LINK_W'(table_address);
        mem_req.wr_data = table_word;
        cur_node_next   = cur_node_reg;
        failed_next     = failed_reg;
        pos_next        = pos_reg;
        letter_next     = letter_reg;
        last_next       = last_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        node_next       = node_reg;
        finish          = 1'b0;
        unique case (state_reg)
            dpl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == dpl_pkg::OP_WRITE)
                    begin
                        mem_req.wr_en = wr_in_range;
                    end
                    else
                    begin
                        letter_next = letter;
                        last_next   = last_letter;
                        if (failed_reg)
                        begin
                            finish = 1'b1;
                        end
                        else if (cur_in_range)
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = cur_node_reg;
                            pos_next        = cur_node_reg;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                            finish      = 1'b1;
                        end
                    end
                end
            end
            dpl_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    cur_node_next = rd_data[dpl_pkg::LINK_W-1:0];
                    finish        = 1'b1;
                end
                else if (scan_go_on)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = pos_inc[dpl_pkg::LINK_W-1:0];
                    pos_next        = pos_inc[dpl_pkg::LINK_W-1:0];
                end
                else
                begin
                    failed_next = 1'b1;
                    finish      = 1'b1;
                end
            end
            default: finish = 1'b0;
        endcase
        if (finish && last_next)
        begin
            done_next     = 1'b1;
            found_next    = !failed_next;
            node_next     = failed_next ? '0 : cur_node_next;
            cur_node_next = '0;
            failed_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dpl_pkg::S_IDLE;
            cur_node_reg <= '0;
            failed_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_node_reg <= cur_node_next;
            failed_reg   <= failed_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        found_reg  <= found_next;
        node_reg   <= node_next;
    end

    assign busy       = state_reg != dpl_pkg::S_IDLE;
    assign done       = done_reg;
    assign word_found = found_reg;
    assign end_node   = node_reg;

    `ASSERT_IMPL(a_done_idle, done_reg, state_reg == dpl_pkg::S_IDLE, "result while scanning")
    `ASSERT_IMPL(a_fail_zero, done_reg && !found_reg, node_reg == '0, "failed word with node")
    `ASSERT_IMPL(a_walk_clear, done_reg, (cur_node_reg == '0) && !failed_reg, "walk not cleared")
    `ASSERT_CLK(a_rd_range, !mem_req.rd_en || ({1'b0, mem_req.rd_addr} < DEPTH_L), "read past table end")
    `ASSERT_CLK(a_rw_excl, !(mem_req.rd_en && mem_req.wr_en), "read and write together")

endmodule

// ===== sv/dawg_path_lookup.sv =====
// top level of the word graph walker: record memory plus scan sequencer
// depends on dpl_pkg, dpl_table and dpl_walk
//
// usage:
//   one command channel: a transfer happens at a rising edge with start high
//   and busy low. opcode selects a table write (table_address, table_word)
//   or a letter lookup (letter, last_letter).
//   a write leaves busy low. writes at or above TABLE_DEPTH
//   are dropped.
//   a lookup reads one sibling record per cycle from the single read port of
//   the record memory: busy stays high while records are scanned, until one
//   matches the letter, the list ends or the table end is reached. a lookup
//   after a failed letter of the same word reads no record; busy stays low.
//   after the last letter, done pulses for one cycle with word_found and
//   end_node, in the cycle after the scan ends; the walk then restarts at node 0.
//   the receiver cannot stall: each result is valid only in the done cycle.
//   reset clears the walk and the result strobe; the record memory is not
//   cleared and holds garbage until written.
module dawg_path_lookup #(
    parameter int unsigned TABLE_DEPTH = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [dpl_pkg::TADDR_W-1:0]   table_address,
    input  logic [dpl_pkg::WORD_W-1:0]    table_word,
    input  logic [dpl_pkg::LETTER_W-1:0]  letter,
    input  logic                          last_letter,
    output logic                          done,
    output logic                          word_found,
    output logic [dpl_pkg::LINK_W-1:0]    end_node
);

    dpl_pkg::mem_req_t          mem_req;
    logic [dpl_pkg::WORD_W-1:0] rd_data;

    dpl_walk #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .table_address (table_address),
        .table_word    (table_word),
        .letter        (letter),
        .last_letter   (last_letter),
        .done          (done),
        .word_found    (word_found),
        .end_node      (end_node),
        .mem_req       (mem_req),
        .rd_data       (rd_data)
    );

    dpl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ===== test/dawg_path_lookup_tb.sv =====
// self-checking testbench for dawg_path_lookup: table writes and letter walks
// depends on dpl_pkg and the dawg_path_lookup rtl; a scoreboard class predicts each result
module dawg_path_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORD_W       = dpl_pkg::WORD_W;
    localparam int unsigned LINK_W       = dpl_pkg::LINK_W;
    localparam int unsigned LETTER_W     = dpl_pkg::LETTER_W;
    localparam int unsigned TADDR_W      = dpl_pkg::TADDR_W;
    localparam int unsigned REC_MORE_BIT = dpl_pkg::REC_MORE_BIT;
    localparam int unsigned REC_LET_LO   = dpl_pkg::REC_LET_LO;
    localparam int unsigned REC_LET_HI   = dpl_pkg::REC_LET_HI;

    localparam int unsigned TABLE_DEPTH = 32768;
    localparam int unsigned NODES       = 96;
    localparam int unsigned ITEM_TARGET = 950;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned MAX_WORD    = 7;

    typedef struct packed {
        logic              found;
        logic [LINK_W-1:0] node;
    } walk_result_t;

    class dpl_scoreboard;
        logic [WORD_W-1:0] rec_mem [TABLE_DEPTH];
        bit                written [TABLE_DEPTH];
        logic [LINK_W-1:0] cur_node  = '0;
        bit                path_dead = 1'b0;
        walk_result_t      pending_results [$];
        int                errors    = 0;

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch: %s expected %0h got %0h", what, want, got);
            end
        endfunction

        // sibling scan from the current node, letter compared before the more flag
        function void walk_letter(logic [LETTER_W-1:0] ch);
            int unsigned       pos;
            logic [WORD_W-1:0] rec;
            pos = 32'(cur_node);
            while (pos < TABLE_DEPTH)
            begin
                rec = rec_mem[pos];
                if (rec[REC_LET_HI:REC_LET_LO] == ch)
                begin
                    cur_node = rec[LINK_W-1:0];
                    return;
                end
                if (!rec[REC_MORE_BIT])
                begin
                    path_dead = 1'b1;
                    return;
                end
                pos++;
            end
            path_dead = 1'b1;
        endfunction

        function void note_input(logic op, logic [TADDR_W-1:0] addr, logic [WORD_W-1:0] word,
                                 logic [LETTER_W-1:0] ch, logic last);
            walk_result_t res;
            if (op == dpl_pkg::OP_WRITE)
            begin
                if (addr < TABLE_DEPTH)
                begin
                    rec_mem[addr] = word;
                    written[addr] = 1'b1;
                end
                return;
            end
            if (!path_dead)
                walk_letter(ch);
            if (last)
            begin
                res.found = !path_dead;
                res.node  = path_dead ? '0 : cur_node;
                pending_results.push_back(res);
                cur_node  = '0;
                path_dead = 1'b0;
            end
        endfunction

        function void check_result(logic found, logic [LINK_W-1:0] node);
            walk_result_t want;
            if (pending_results.size() == 0)
            begin
                flag("result with nothing pending, end_node", 0, 32'(node));
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found)
                flag("word_found", 32'(want.found), 32'(found));
            if (node !== want.node)
                flag("end_node", 32'(want.node), 32'(node));
        endfunction

        // true when the scan for ch touches only written records
        function bit scan_safe(logic [LETTER_W-1:0] ch);
            int unsigned pos;
            if (path_dead)
                return 1'b1;
            pos = 32'(cur_node);
            while (pos < TABLE_DEPTH)
            begin
                if (!written[pos])
                    return 1'b0;
                if (rec_mem[pos][REC_LET_HI:REC_LET_LO] == ch || !rec_mem[pos][REC_MORE_BIT])
                    return 1'b1;
                pos++;
            end
            return 1'b1;
        endfunction

        // a letter present among the written siblings of the current node, else a random one
        function logic [LETTER_W-1:0] chain_letter();
            logic [LETTER_W-1:0] sibs [$];
            int unsigned         pos;
            pos = 32'(cur_node);
            while (pos < TABLE_DEPTH && written[pos] && sibs.size() < 32)
            begin
                sibs.push_back(rec_mem[pos][REC_LET_HI:REC_LET_LO]);
                if (!rec_mem[pos][REC_MORE_BIT])
                    break;
                pos++;
            end
            if (sibs.size() == 0)
                return LETTER_W'($urandom_range(0, 127));
            return sibs[$urandom_range(0, sibs.size() - 1)];
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic                opcode        = dpl_pkg::OP_WRITE;
    logic [TADDR_W-1:0]  table_address = '0;
    logic [WORD_W-1:0]   table_word    = '0;
    logic [LETTER_W-1:0] letter        = '0;
    logic                last_letter   = 1'b0;
    logic                busy;
    logic                done;
    logic                word_found;
    logic [LINK_W-1:0]   end_node;

    dpl_scoreboard board = new;
    bit            idle_on    = 1'b1;
    int unsigned   item_count = 0;
    int unsigned   stall_cycles;

    always #1 clk = ~clk;

    dawg_path_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .table_address(table_address),
        .table_word   (table_word),
        .letter       (letter),
        .last_letter  (last_letter),
        .done         (done),
        .word_found   (word_found),
        .end_node     (end_node)
    );

    function automatic logic [WORD_W-1:0] pack_rec(bit more, logic [LETTER_W-1:0] ch,
                                                   logic [LINK_W-1:0] link);
        return {more, ch, link};
    endfunction

    function automatic logic [LINK_W-1:0] rand_link();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
            return LINK_W'($urandom_range(0, NODES - 1));
        else if (pick == 7)
            return LINK_W'(TABLE_DEPTH - 3 + $urandom_range(0, 2));
        else if (pick == 8)
            return LINK_W'($urandom_range(TABLE_DEPTH, 24'hffffff));
        return LINK_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] rand_record(bit more);
        logic [LETTER_W-1:0] ch;
        ch = ($urandom_range(0, 4) != 0) ? LETTER_W'(7'h61 + $urandom_range(0, 7))
                                         : LETTER_W'($urandom_range(0, 127));
        return pack_rec(more, ch, rand_link());
    endfunction

    task automatic send_item(logic op, logic [TADDR_W-1:0] addr, logic [WORD_W-1:0] word,
                             logic [LETTER_W-1:0] ch, logic last);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        opcode        <= op;
        table_address <= addr;
        table_word    <= word;
        letter        <= ch;
        last_letter   <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_input(op, addr, word, ch, last);
        if (op == dpl_pkg::OP_LOOKUP || addr < TABLE_DEPTH)
            item_count++;
    endtask

    task automatic send_write(logic [TADDR_W-1:0] addr, logic [WORD_W-1:0] word);
        send_item(dpl_pkg::OP_WRITE, addr, word, LETTER_W'($urandom), 1'($urandom));
    endtask

    task automatic send_lookup(logic [LETTER_W-1:0] ch, logic last);
        send_item(dpl_pkg::OP_LOOKUP, TADDR_W'($urandom), WORD_W'($urandom), ch, last);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            board.check_result(word_found, end_node);
    end

    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("dawg_path_lookup verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned         step;
        int unsigned         word_len;
        logic [LETTER_W-1:0] ch;
        logic                last;
        logic [TADDR_W-1:0]  addr;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // root siblings, a short word, a tail chain that runs off the table end
        send_write(16'd0, pack_rec(1'b1, 7'h63, 24'd4));
        send_write(16'd1, pack_rec(1'b1, 7'h00, 24'd8));
        send_write(16'd2, pack_rec(1'b1, 7'h7a, LINK_W'(TABLE_DEPTH - 3)));
        send_write(16'd3, pack_rec(1'b0, 7'h7f, 24'hffffff));
        send_write(16'd4, pack_rec(1'b0, 7'h61, 24'd5));
        send_write(16'd5, pack_rec(1'b0, 7'h74, 24'h000010));
        send_write(TADDR_W'(TABLE_DEPTH - 3), pack_rec(1'b1, 7'h71, 24'd0));
        send_write(TADDR_W'(TABLE_DEPTH - 2), pack_rec(1'b1, 7'h72, 24'd1));
        send_write(TADDR_W'(TABLE_DEPTH - 1), pack_rec(1'b1, 7'h73, 24'h123456));
        send_write(16'hffff, 32'hffffffff);
        send_lookup(7'h63, 1'b0);
        send_lookup(7'h61, 1'b0);
        send_lookup(7'h74, 1'b1);
        send_lookup(7'h63, 1'b0);
        send_lookup(7'h78, 1'b1);
        send_lookup(7'h71, 1'b0);
        send_lookup(7'h63, 1'b1);
        send_lookup(7'h7f, 1'b1);
        send_lookup(7'h7f, 1'b0);
        send_lookup(7'h61, 1'b1);
        send_lookup(7'h7a, 1'b0);
        send_lookup(7'h73, 1'b1);
        send_lookup(7'h7a, 1'b0);
        send_lookup(7'h77, 1'b1);
        send_lookup(7'h00, 1'b1);
        send_lookup(7'h63, 1'b0);
        send_write(16'd4, pack_rec(1'b0, 7'h6f, 24'd6));
        send_lookup(7'h6f, 1'b1);
        wait_drained();

        for (int unsigned a = 0; a < NODES; a++)
        begin
            send_write(TADDR_W'(a), rand_record(a != NODES - 1 && $urandom_range(0, 3) != 0));
        end

        step     = 0;
        word_len = 0;
        while (item_count < ITEM_TARGET)
        begin
            step++;
            if (step % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (step % 250 == 0)
                wait_drained();
            if ($urandom_range(0, 99) < 8)
            begin
                addr = ($urandom_range(0, 1) != 0) ? TADDR_W'($urandom_range(0, NODES - 1))
                                                   : TADDR_W'($urandom);
                send_write(addr, ($urandom_range(0, 1) != 0) ? rand_record(1'($urandom))
                                                             : WORD_W'($urandom));
            end
            else if (!board.path_dead && board.cur_node < TABLE_DEPTH
                     && !board.written[board.cur_node])
            begin
                send_write(board.cur_node[TADDR_W-1:0], rand_record(1'($urandom)));
            end
            else
            begin
                ch = ($urandom_range(0, 3) != 0) ? board.chain_letter()
                                                 : LETTER_W'($urandom_range(0, 127));
                if (!board.scan_safe(ch))
                    ch = board.rec_mem[board.cur_node][REC_LET_HI:REC_LET_LO];
                word_len++;
                last = (word_len >= MAX_WORD) || ($urandom_range(0, 3) == 0);
                send_lookup(ch, last);
                if (last)
                    word_len = 0;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (board.pending_results.size() != 0)
            board.flag("results never arrived, count", board.pending_results.size(), 0);
        if (board.errors == 0)
            $display("dawg_path_lookup verification clean");
        else
            $display("dawg_path_lookup verification failed");
        $finish;
    end

endmodule

// ===== dawg_path_lookup.f =====
+incdir+sv
sv/dpl_pkg.sv
sv/dpl_table.sv
sv/dpl_walk.sv
sv/dawg_path_lookup.sv
test/dawg_path_lookup_tb.sv
